/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* rtl/rrd_pkg.sv */
// ----------------------------------------------------------------------------
// rrd_pkg
// Types, stage map and fixed-point helpers of the ray refraction pipeline.
// ----------------------------------------------------------------------------
package rrd_pkg;

    // Stage map of the pipeline
    localparam int SqlN    = 30;                // bits of the length square root
    localparam int DivN    = 16;                // quotient bits of the normalize
    localparam int SqsN    = 19;                // bits of the sqrt(cosT2) root
    localparam int StSq    = 1;
    localparam int StLen   = 2;
    localparam int StSql0  = 3;
    localparam int StDivI  = StSql0 + SqlN;
    localparam int StDiv0  = StDivI + 1;
    localparam int StDot1  = StDiv0 + DivN;
    localparam int StDot2  = StDot1 + 1;
    localparam int StE1    = StDot2 + 1;
    localparam int StE2    = StE1 + 1;
    localparam int StE3    = StE2 + 1;
    localparam int StE4    = StE3 + 1;
    localparam int StSqs0  = StE4 + 1;
    localparam int StG1    = StSqs0 + SqsN;
    localparam int StG2    = StG1 + 1;
    localparam int NStages = StG2 + 1;

    localparam logic [14:0] TirThresholdReset = 15'd16;

    // Payload of one ray as it moves down the pipeline
    typedef struct packed {
        logic              deg;
        logic              tir;
        logic [2:0][15:0]  d;
        logic [2:0][15:0]  nv;
        logic [15:0]       n;
        logic [2:0][30:0]  sq;
        logic [59:0]       sqx;
        logic [59:0]       sqr;
        logic [2:0][45:0]  rem;
        logic [2:0][15:0]  q;
        logic [2:0][16:0]  vv;
        logic [2:0][32:0]  dp;
        logic [31:0]       nn;
        logic [18:0]       n2;
        logic [17:0]       cosi;
        logic [20:0]       ncos;
        logic [35:0]       csq;
        logic [37:0]       ph;
        logic [36:0]       pl;
        logic [41:0]       rp;
        logic [2:0][33:0]  pa;
        logic [2:0][37:0]  pb;
        logic [2:0][33:0]  pc;
        logic [2:0][15:0]  o;
    } pipe_t;

    // Divide by 2^14, rounding half away from zero
    function automatic logic signed [41:0] rnd14(input logic signed [55:0] x);
        logic [55:0] m;
        m = x[55] ? (56'd0 - x) : x;
        m = (m + 56'd8192) >> 14;
        rnd14 = x[55] ? $signed(42'd0 - m[41:0]) : $signed(m[41:0]);
    endfunction

    // Clamp to signed 16 bits
    function automatic logic [15:0] sat16(input logic signed [41:0] v);
        if (v > 42'sd32767)
            sat16 = 16'h7FFF;
        else if (v < -42'sd32768)
            sat16 = 16'h8000;
        else
            sat16 = v[15:0];
    endfunction

endpackage

/* rtl/ray_refract_direction_core.sv */
// ----------------------------------------------------------------------------
// ray_refract_direction_core
// Snell refraction of a ray direction with total internal reflection fallback.
//
// Input beat (in_valid/in_ready): direction dir_* (Q3.12, any length), unit
// normal normal_* (Q1.14) and index ratio index_ratio (Q2.14). Output beat
// (out_valid/out_ready): out_* (Q1.14, saturated), reflected, degenerate.
// One ray enters per cycle while in_ready is high. The depth is set by the
// bit-per-stage length square root (30 stages), the bit-per-stage normalize
// divider (16 stages) and the sqrt(cosT2) root (19 stages), plus the
// multiply and round stages.
// When the output beat is held, the whole pipeline freezes and in_ready
// drops in the same cycle; no ray is lost or repeated. Bubbles move on
// whenever the output register is empty.
// Reset clears every valid bit and sets tir_threshold to 16. Write the
// threshold through cfg_wr_en/cfg_wr_data only while no ray is in flight.
// A zero direction yields zero output with degenerate set.
// ----------------------------------------------------------------------------
module ray_refract_direction_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [14:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] dir_z,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic signed [15:0] normal_z,
    input  logic [15:0]        index_ratio,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic signed [15:0] out_z,
    output logic               reflected,
    output logic               degenerate
);

    localparam int Last = rrd_pkg::NStages - 1;

    logic [14:0]                   tir_threshold_reg;
    logic [rrd_pkg::NStages-1:0]   vld_reg;
    rrd_pkg::pipe_t                pipe_reg  [rrd_pkg::NStages];
    rrd_pkg::pipe_t                pipe_next [rrd_pkg::NStages];
    logic                          en;

    // Advance everything unless the output beat is held
    assign en       = out_ready | ~vld_reg[Last];
    assign in_ready = en;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tir_threshold_reg <= rrd_pkg::TirThresholdReset;
        else if (cfg_wr_en)
            tir_threshold_reg <= cfg_wr_data;
    end

    // Capture the input beat
    always_comb
    begin
        pipe_next[0]       = '0;
        pipe_next[0].d[0]  = dir_x;
        pipe_next[0].d[1]  = dir_y;
        pipe_next[0].d[2]  = dir_z;
        pipe_next[0].nv[0] = normal_x;
        pipe_next[0].nv[1] = normal_y;
        pipe_next[0].nv[2] = normal_z;
        pipe_next[0].n     = index_ratio;
    end

    for (genvar i = 1; i < rrd_pkg::NStages; i++)
    begin : g_st
        if (i == rrd_pkg::StSq)
        begin : g_sq
            // Square each direction component
            always_comb
            begin
                rrd_pkg::pipe_t p;
                logic signed [31:0] s;
                p = pipe_reg[i-1];
                for (int k = 0; k < 3; k++)
                begin
                    s = $signed(p.d[k]) * $signed(p.d[k]);
                    p.sq[k] = s[30:0];
                end
                pipe_next[i] = p;
            end
        end
        else if (i == rrd_pkg::StLen)
        begin : g_len
            // Sum the squares, flag a zero direction, seed the root
            always_comb
            begin
                rrd_pkg::pipe_t p;
                logic [31:0] len2;
                p = pipe_reg[i-1];
                len2  = {1'b0, p.sq[0]} + {1'b0, p.sq[1]} + {1'b0, p.sq[2]};
                p.deg = (len2 == 32'd0);
                p.sqx = {len2, 28'd0};
                p.sqr = '0;
                pipe_next[i] = p;
            end
        end
        else if (i >= rrd_pkg::StSql0 && i < rrd_pkg::StDivI)
        begin : g_sql
            localparam int J = i - rrd_pkg::StSql0;
            // One bit of the length square root
            always_comb
            begin
                rrd_pkg::pipe_t p;
                logic [59:0] bitv;
                logic [59:0] t;
                p = pipe_reg[i-1];
                bitv = 60'd1 << (58 - 2 * J);
                t    = p.sqr + bitv;
                if (p.sqx >= t)
                begin
                    p.sqx = p.sqx - t;
                    p.sqr = (p.sqr >> 1) + bitv;
                end
                else
                    p.sqr = p.sqr >> 1;
                pipe_next[i] = p;
            end
        end
        else if (i == rrd_pkg::StDivI)
        begin : g_divi
            // Set up the normalize: numerator |d|*2^28 + L/2 over L
            always_comb
            begin
                rrd_pkg::pipe_t p;
                logic [29:0] dv;
                logic [15:0] mag;
                p = pipe_reg[i-1];
                dv = p.deg ? 30'd1 : p.sqr[29:0];
                p.sqr = {30'd0, dv};
                for (int k = 0; k < 3; k++)
                begin
                    mag = p.d[k][15] ? (16'd0 - p.d[k]) : p.d[k];
                    p.rem[k] = (46'(mag) << 28) + 46'(dv >> 1);
                    p.q[k]   = '0;
                end
                pipe_next[i] = p;
            end
        end
        else if (i >= rrd_pkg::StDiv0 && i < rrd_pkg::StDot1)
        begin : g_div
            localparam int B = rrd_pkg::DivN - 1 - (i - rrd_pkg::StDiv0);
            // One quotient bit for each component
            always_comb
            begin
                rrd_pkg::pipe_t p;
                logic [45:0] sh;
                p = pipe_reg[i-1];
                sh = 46'(p.sqr[29:0]) << B;
                for (int k = 0; k < 3; k++)
                begin
                    if (p.rem[k] >= sh)
                    begin
                        p.rem[k]  = p.rem[k] - sh;
                        p.q[k][B] = 1'b1;
                    end
                end
                pipe_next[i] = p;
            end
        end
        else if (i == rrd_pkg::StDot1)
        begin : g_dot1
            // Restore sign, multiply by the normal, square the ratio
            always_comb
            begin
                rrd_pkg::pipe_t p;
                p = pipe_reg[i-1];
                for (int k = 0; k < 3; k++)
                begin
                    p.vv[k] = p.d[k][15] ? (17'd0 - {1'b0, p.q[k]}) : {1'b0, p.q[k]};
                    p.dp[k] = $signed(p.nv[k]) * $signed(p.vv[k]);
                end
                p.nn = p.n * p.n;
                pipe_next[i] = p;
            end
        end
        else if (i == rrd_pkg::StDot2)
        begin : g_dot2
            // Form cosI and n^2
            always_comb
            begin
                rrd_pkg::pipe_t p;
                logic signed [34:0] dot;
                logic signed [41:0] r1;
                logic signed [41:0] r2;
                p = pipe_reg[i-1];
                dot = $signed(p.dp[0]) + $signed(p.dp[1]) + $signed(p.dp[2]);
                r1  = rrd_pkg::rnd14(-dot);
                r2  = rrd_pkg::rnd14({24'd0, p.nn});
                p.cosi = r1[17:0];
                p.n2   = r2[18:0];
                pipe_next[i] = p;
            end
        end
        else if (i == rrd_pkg::StE1)
        begin : g_e1
            // Square cosI, scale it by the ratio
            always_comb
            begin
                rrd_pkg::pipe_t p;
                logic signed [41:0] r;
                p = pipe_reg[i-1];
                p.csq  = $signed(p.cosi) * $signed(p.cosi);
                r      = rrd_pkg::rnd14($signed({1'b0, p.n}) * $signed(p.cosi));
                p.ncos = r[20:0];
                pipe_next[i] = p;
            end
        end
        else if (i == rrd_pkg::StE2)
        begin : g_e2
            // n^2 * (1 - cosI^2) as two partial products
            always_comb
            begin
                rrd_pkg::pipe_t p;
                logic signed [35:0] a;
                p = pipe_reg[i-1];
                a    = 36'sd268435456 - $signed(p.csq);
                p.ph = $signed({1'b0, p.n2}) * $signed(a[35:18]);
                p.pl = p.n2 * a[17:0];
                pipe_next[i] = p;
            end
        end
        else if (i == rrd_pkg::StE3)
        begin : g_e3
            // Join the partial products and round
            always_comb
            begin
                rrd_pkg::pipe_t p;
                logic signed [55:0] prod;
                p = pipe_reg[i-1];
                prod = ($signed(p.ph) <<< 18) + $signed({1'b0, p.pl});
                p.rp = rrd_pkg::rnd14(prod);
                pipe_next[i] = p;
            end
        end
        else if (i == rrd_pkg::StE4)
        begin : g_e4
            // Form cosT2, pick refract or reflect, seed the second root
            always_comb
            begin
                rrd_pkg::pipe_t p;
                logic signed [42:0] cost2;
                p = pipe_reg[i-1];
                cost2 = 43'sd268435456 - $signed(p.rp);
                p.tir = !(cost2 > $signed({14'd0, tir_threshold_reg, 14'd0}));
                p.sqx = p.tir ? 60'd0 : {22'd0, cost2[37:0]};
                p.sqr = '0;
                pipe_next[i] = p;
            end
        end
        else if (i >= rrd_pkg::StSqs0 && i < rrd_pkg::StG1)
        begin : g_sqs
            localparam int J = i - rrd_pkg::StSqs0;
            // One bit of sqrt(cosT2)
            always_comb
            begin
                rrd_pkg::pipe_t p;
                logic [37:0] bitv;
                logic [37:0] t;
                p = pipe_reg[i-1];
                bitv = 38'd1 << (36 - 2 * J);
                t    = p.sqr[37:0] + bitv;
                if (p.sqx[37:0] >= t)
                begin
                    p.sqx = {22'd0, p.sqx[37:0] - t};
                    p.sqr = {22'd0, (p.sqr[37:0] >> 1) + bitv};
                end
                else
                    p.sqr = {22'd0, p.sqr[37:0] >> 1};
                pipe_next[i] = p;
            end
        end
        else if (i == rrd_pkg::StG1)
        begin : g_g1
            // Products of both candidate directions
            always_comb
            begin
                rrd_pkg::pipe_t p;
                logic signed [21:0] k;
                p = pipe_reg[i-1];
                k = $signed(p.ncos) - $signed({3'b000, p.sqr[18:0]});
                for (int c = 0; c < 3; c++)
                begin
                    p.pa[c] = $signed(p.vv[c]) * $signed({1'b0, p.n});
                    p.pb[c] = $signed(p.nv[c]) * k;
                    p.pc[c] = $signed(p.cosi) * $signed(p.nv[c]);
                end
                pipe_next[i] = p;
            end
        end
        else
        begin : g_g2
            // Sum, round, saturate and select the result
            always_comb
            begin
                rrd_pkg::pipe_t p;
                logic signed [38:0] rf;
                logic signed [35:0] rl;
                logic signed [35:0] vs;
                p = pipe_reg[i-1];
                for (int c = 0; c < 3; c++)
                begin
                    rf = $signed(p.pa[c]) + $signed(p.pb[c]);
                    vs = $signed(p.vv[c]);
                    rl = (vs <<< 14) + ($signed(p.pc[c]) <<< 1);
                    if (p.deg)
                        p.o[c] = '0;
                    else if (p.tir)
                        p.o[c] = rrd_pkg::sat16(rrd_pkg::rnd14(rl));
                    else
                        p.o[c] = rrd_pkg::sat16(rrd_pkg::rnd14(rf));
                end
                pipe_next[i] = p;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en)
            pipe_reg <= pipe_next;
    end

    // Valid bits travel with the payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[Last-1:0], in_valid};
    end

    // Drive the output beat
    assign out_valid  = vld_reg[Last];
    assign out_x      = $signed(pipe_reg[Last].o[0]);
    assign out_y      = $signed(pipe_reg[Last].o[1]);
    assign out_z      = $signed(pipe_reg[Last].o[2]);
    assign reflected  = pipe_reg[Last].tir & ~pipe_reg[Last].deg;
    assign degenerate = pipe_reg[Last].deg;

endmodule

/* rtl/rrd_checker.sv */
// ----------------------------------------------------------------------------
// rrd_checker
// Port-level checks of the ray refraction core, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rrd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] out_x,
    input logic signed [15:0] out_y,
    input logic signed [15:0] out_z,
    input logic               reflected,
    input logic               degenerate
);

    // A held output beat keeps its payload
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(reflected) && $stable(degenerate))

    // A zero direction gives a zero, non-reflected result
    `ASSERT_IMPLY(a_deg_zero, clk, rst_n, out_valid && degenerate, out_x == 16'sd0 && out_y == 16'sd0 && out_z == 16'sd0 && !reflected)

    // Input side stalls only behind a held output beat
    `ASSERT_IMPLY(a_stall_cause, clk, rst_n, !in_ready, out_valid && !out_ready)

    // An empty output register never blocks the input
    `ASSERT_IMPLY(a_empty_ready, clk, rst_n, !out_valid, in_ready)

endmodule

bind ray_refract_direction_core rrd_checker u_rrd_checker (.*);

/* verif/ray_refract_direction_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_refract_direction_core_tb
// Drives rays through the refraction pipeline with random handshake gaps and
// checks each output beat against a behavioral fixed-point refraction model,
// over several threshold settings and one long output stall.
// ----------------------------------------------------------------------------
module ray_refract_direction_core_tb;

    localparam int WatchdogLimit     = 20000;
    localparam int DrainCycles       = 120;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               refl;
        logic               deg;
    } ray_out_t;

    typedef struct {
        logic signed [15:0] dx, dy, dz, nx, ny, nz;
        logic [15:0]        n;
        logic               known;
        ray_out_t           res;
    } ray_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [14:0]        cfg_wr_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] dir_x, dir_y, dir_z;
    logic signed [15:0] normal_x, normal_y, normal_z;
    logic [15:0]        index_ratio;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] out_x, out_y, out_z;
    logic               reflected;
    logic               degenerate;

    ray_out_t    expected_rays[$];
    logic [14:0] threshold;
    int          errors;
    int          rays_sent;
    int          rays_checked;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_output;
    bit          done;

    ray_refract_direction_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .dir_x       (dir_x),
        .dir_y       (dir_y),
        .dir_z       (dir_z),
        .normal_x    (normal_x),
        .normal_y    (normal_y),
        .normal_z    (normal_z),
        .index_ratio (index_ratio),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .reflected   (reflected),
        .degenerate  (degenerate)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Divide by 2^s, rounding half away from zero
    function automatic longint round_shift(longint x, int s);
        longint h;
        h = 64'sd1 <<< (s - 1);
        if (x >= 0)
            return (x + h) >>> s;
        return -((-x + h) >>> s);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // Normalize the direction, then refract or mirror it
    function automatic ray_out_t refract_ray(ray_row_t r, logic [14:0] thr);
        ray_out_t        o;
        longint          d[3], nv[3], v[3], o3[3];
        longint unsigned len2, len, mag;
        longint          q, dot, cos_i, n, n2, cos_t2, s, k;
        d[0] = r.dx;  d[1] = r.dy;  d[2] = r.dz;
        nv[0] = r.nx; nv[1] = r.ny; nv[2] = r.nz;
        n = r.n;
        len2 = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        o = '{x: 0, y: 0, z: 0, refl: 1'b0, deg: 1'b1};
        if (len2 == 0)
            return o;
        len = int_sqrt(len2 << 28);
        dot = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag = d[i] < 0 ? -d[i] : d[i];
            q = ((mag << 28) + (len >> 1)) / len;
            v[i] = d[i] < 0 ? -q : q;
            dot += nv[i] * v[i];
        end
        cos_i = round_shift(-dot, 14);
        n2 = round_shift(n * n, 14);
        cos_t2 = (64'sd1 <<< 28) - round_shift(n2 * ((64'sd1 <<< 28) - cos_i * cos_i), 14);
        o.deg = 1'b0;
        if (cos_t2 > (longint'(thr) <<< 14))
        begin
            s = int_sqrt(cos_t2);
            k = round_shift(n * cos_i, 14) - s;
            for (int i = 0; i < 3; i++)
                o3[i] = round_shift(v[i] * n + nv[i] * k, 14);
            o.refl = 1'b0;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
                o3[i] = round_shift(v[i] * (64'sd1 <<< 14) + 2 * cos_i * nv[i], 14);
            o.refl = 1'b1;
        end
        o.x = clamp16(o3[0]);
        o.y = clamp16(o3[1]);
        o.z = clamp16(o3[2]);
        return o;
    endfunction

    // Normal mostly along one axis, either sign, with small other parts; sometimes any value
    function automatic ray_row_t random_ray();
        ray_row_t r;
        int       axis;
        r.dx = 16'($urandom);
        r.dy = 16'($urandom);
        r.dz = 16'($urandom);
        if ($urandom_range(0, 3) == 0)
        begin
            r.dx = 16'(int'($urandom_range(0, 64)) - 32);
            r.dy = 16'(int'($urandom_range(0, 64)) - 32);
            r.dz = 16'(int'($urandom_range(0, 64)) - 32);
        end
        if ($urandom_range(0, 4) == 0)
        begin
            r.nx = 16'($urandom);
            r.ny = 16'($urandom);
            r.nz = 16'($urandom);
        end
        else
        begin
            axis = $urandom_range(0, 2);
            r.nx = 16'(int'($urandom_range(0, 200)) - 100);
            r.ny = 16'(int'($urandom_range(0, 200)) - 100);
            r.nz = 16'(int'($urandom_range(0, 200)) - 100);
            case (axis)
                0: r.nx = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
                1: r.ny = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
                default: r.nz = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
            endcase
        end
        r.n = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(8192, 32768));
        r.known = 1'b0;
        return r;
    endfunction

    // Offer one beat, hold it until taken, then record what it must yield
    task automatic send_ray(ray_row_t r);
        while (!hold_output && ($urandom_range(1, 100) <= send_idle_pct))
            @(negedge clk);
        dir_x = r.dx; dir_y = r.dy; dir_z = r.dz;
        normal_x = r.nx; normal_y = r.ny; normal_z = r.nz;
        index_ratio = r.n;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_rays.push_back(r.known ? r.res : refract_ray(r, threshold));
        rays_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Write the threshold once the pipeline has drained
    task automatic write_threshold(logic [14:0] value);
        while (expected_rays.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        threshold = value;
    endtask

    // Receiver: random stalls, or a long hold when asked
    always @(negedge clk)
    begin
        if (hold_output)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
    end

    // Compare each output beat with the oldest expected ray
    always @(posedge clk)
    begin
        ray_out_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_rays.size() == 0)
            begin
                $error("unexpected output beat");
                errors++;
            end
            else
            begin
                e = expected_rays.pop_front();
                rays_checked++;
                if (out_x !== e.x)
                begin
                    $error("out_x exp %0d got %0d", e.x, out_x);
                    errors++;
                end
                if (out_y !== e.y)
                begin
                    $error("out_y exp %0d got %0d", e.y, out_y);
                    errors++;
                end
                if (out_z !== e.z)
                begin
                    $error("out_z exp %0d got %0d", e.z, out_z);
                    errors++;
                end
                if (reflected !== e.refl)
                begin
                    $error("reflected exp %0b got %0b", e.refl, reflected);
                    errors++;
                end
                if (degenerate !== e.deg)
                begin
                    $error("degenerate exp %0b got %0b", e.deg, degenerate);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit && !done)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        ray_row_t rows[$];
        ray_row_t r;
        logic [14:0] thresholds[5];
        int       lim;
        errors = 0; rays_sent = 0; rays_checked = 0; idle_cycles = 0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_output = 1'b0; done = 1'b0;
        rst_n = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0; in_valid = 1'b0;
        out_ready = 1'b0;
        dir_x = '0; dir_y = '0; dir_z = '0;
        normal_x = '0; normal_y = '0; normal_z = '0; index_ratio = '0;
        threshold = rrd_pkg::TirThresholdReset;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed rays; fixed results where obvious
        rows.push_back('{0, 0, 0, 16384, 0, 0, 16384, 1, '{0, 0, 0, 0, 1}});
        rows.push_back('{0, 0, 0, -16384, 16384, 16384, 65535, 1, '{0, 0, 0, 0, 1}});
        // Straight through at n = 1: same direction out
        rows.push_back('{0, 0, -4096, 0, 0, 16384, 16384, 1, '{0, 0, -16384, 0, 0}});
        rows.push_back('{4096, 0, 0, -16384, 0, 0, 16384, 1, '{16384, 0, 0, 0, 0}});
        rows.push_back('{-32768, 0, 0, 16384, 0, 0, 16384, 0, '{0, 0, 0, 0, 0}});
        rows.push_back('{32767, 32767, 32767, 0, 16384, 0, 16384, 0, '{0, 0, 0, 0, 0}});
        rows.push_back('{-32768, -32768, -32768, 16384, 16384, 16384, 65535, 0,
                        '{0, 0, 0, 0, 0}});
        rows.push_back('{1, 0, 0, -16384, 0, 0, 0, 0, '{0, 0, 0, 0, 0}});
        rows.push_back('{0, -1, 0, 0, 16384, 0, 65535, 0, '{0, 0, 0, 0, 0}});
        rows.push_back('{3000, 0, -3000, 0, 0, 16384, 24576, 0, '{0, 0, 0, 0, 0}});
        rows.push_back('{4000, 0, -1000, 0, 0, 16384, 24576, 0, '{0, 0, 0, 0, 0}});
        rows.push_back('{100, 200, -300, 16384, -16384, 16384, 12000, 0, '{0, 0, 0, 0, 0}});
        rows.push_back('{-32768, 32767, 0, -32768, 32767, -32768, 65535, 0,
                        '{0, 0, 0, 0, 0}});
        rows.push_back('{5, -7, 9, 16384, 0, 0, 16384, 0, '{0, 0, 0, 0, 0}});
        foreach (rows[i])
            send_ray(rows[i]);

        // Random rays over threshold settings and handshake phases
        thresholds = '{15'd0, 15'd16384, 15'h7FFF, 15'd2000, 15'd16};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_threshold(thresholds[ph]);
            for (int sub = 0; sub < 4; sub++)
            begin
                send_idle_pct  = (sub == 1 || sub == 3) ? (sub == 3 ? 33 : 66) : 0;
                recv_stall_pct = (sub == 2 || sub == 3) ? (sub == 3 ? 33 : 66) : 0;
                lim = 72;
                if (ph == 0 && sub == 0)
                begin
                    // Long output hold: pipeline fills and in_ready drops
                    fork
                        begin
                            hold_output = 1'b1;
                            repeat (300) @(negedge clk);
                            hold_output = 1'b0;
                        end
                    join_none
                end
                for (int k = 0; k < lim; k++)
                begin
                    r = random_ray();
                    send_ray(r);
                end
            end
        end

        while (expected_rays.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
        done = 1'b1;
        $display("run: %0d rays sent, %0d checked, five threshold settings incl. 0 and max",
                 rays_sent, rays_checked);
        $display("run: idle/stall mixes and one long output hold covered");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/rrd_pkg.sv
rtl/ray_refract_direction_core.sv
rtl/rrd_checker.sv
verif/ray_refract_direction_core_tb.sv
